[hdl/bcr_pkg.sv]
// shared types and constants for the bisection cubic root finder
// no dependencies

package bcr_pkg;

  localparam int DATA_W        = 32;
  localparam int ACC_W         = 64;
  localparam int STEPS_W       = 7;
  localparam int TOL_W         = 31;
  localparam int LIMIT_W       = 7;
  localparam int CFG_IDX_W     = 3;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_STEPS_DEF = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_CUBIC    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_SQUARE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_LINEAR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_CONSTANT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_TOL     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_THRESH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT    = 3'd6;

  typedef enum logic [1:0] {
    STOP_WIDTH = 2'd0,
    STOP_ZERO  = 2'd1,
    STOP_LIMIT = 2'd2
  } stop_reason_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ACC,
    ST_TEST,
    ST_DONE
  } state_e;

endpackage

[hdl/bisection_cubic_root_top.sv]
// bisection root finder for a cubic in signed fixed point, one shared multiplier; uses bcr_pkg
// each evaluation, of f(a) once and of each midpoint, costs a check state, three horner steps on
//   one 33x32 multiplier (low partial product, high partial product, accumulate) and a test
//   state; a narrow start bracket or the step cap stops in the check state
// throughput: one bracket at a time, a new word is taken in the cycle after the result moves into
//   the output register; reset: coefficients and limits to defaults, block idle, output empty

module bisection_cubic_root_top #(
  parameter int FRAC_BITS = bcr_pkg::FRAC_BITS_DEF,
  parameter int MAX_STEPS = bcr_pkg::MAX_STEPS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [bcr_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [bcr_pkg::DATA_W-1:0]           cfg_data_i,
  // bracket words in
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [bcr_pkg::DATA_W-1:0]    start_low_i,
  input  logic signed [bcr_pkg::DATA_W-1:0]    start_high_i,
  // result words out
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [bcr_pkg::DATA_W-1:0]    root_o,
  output logic [bcr_pkg::STEPS_W-1:0]          steps_taken_o,
  output logic [1:0]                           stop_reason_o
);
  import bcr_pkg::*;

  localparam int CntW = $clog2(MAX_STEPS + 1);
  localparam int ProdW = 2 * DATA_W + 1;        // 33x32 signed partial product
  localparam int WideW = ACC_W + DATA_W + 1;    // full acc*x product with headroom
  localparam logic [LIMIT_W-1:0] MaxLim = LIMIT_W'(MAX_STEPS);
  localparam logic signed [DATA_W-1:0] CubicRst  = DATA_W'(2 <<< FRAC_BITS);
  localparam logic signed [DATA_W-1:0] SquareRst = DATA_W'(-(4 <<< FRAC_BITS));
  localparam logic signed [DATA_W-1:0] LinearRst = DATA_W'(3 <<< FRAC_BITS);
  localparam logic signed [ACC_W-1:0]  AccMax = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0]  AccMin = {1'b1, {(ACC_W-1){1'b0}}};

  // configuration registers
  logic signed [DATA_W-1:0] coef_cubic_q, coef_square_q, coef_linear_q, coef_const_q;
  logic [TOL_W-1:0]         width_tol_q, zero_thr_q;
  logic [LIMIT_W-1:0]       iter_limit_q;

  // control
  state_e       state_q, state_d;
  logic         out_valid_q;
  logic [1:0]   hstep_q;        // horner step 0..2, reads 3 after the last
  logic         eval_a_q;       // current evaluation is f(a), not f(c)
  logic         fa_known_q;
  logic         fa_neg_q, fa_pos_q;

  // datapath
  logic signed [DATA_W-1:0] a_q, b_q, c_q, x_q;
  logic [CntW-1:0]          steps_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ProdW-1:0]  pp_lo_q, pp_hi_q;
  stop_reason_e             reason_q;
  logic signed [DATA_W-1:0] root_q;
  logic [STEPS_W-1:0]       steps_out_q;
  stop_reason_e             reason_out_q;

  // combinational
  logic                     accept_in, load_out;
  logic signed [DATA_W:0]   mul_a;
  logic signed [ProdW-1:0]  mul_p;
  logic signed [DATA_W-1:0] coef_sel;
  logic signed [DATA_W:0]   diff, sum_ab;
  logic [DATA_W:0]          width;
  logic                     width_low, at_limit;
  logic [LIMIT_W-1:0]       lim_eff;
  logic signed [DATA_W-1:0] mid;
  logic signed [WideW-1:0]  prod_full, prod_sh;
  logic signed [ACC_W-1:0]  prod_sat, horner_next;
  logic signed [ACC_W:0]    add_sum;
  logic [ACC_W-1:0]         fc_mag;
  logic                     fc_small, fc_neg, fc_pos, go_left;

  // bracket width, step cap and midpoint
  always_comb begin
    diff      = {a_q[DATA_W-1], a_q} - {b_q[DATA_W-1], b_q};
    width     = diff[DATA_W] ? (DATA_W+1)'(0) - diff : diff;
    width_low = width < {2'b00, width_tol_q};
    if (iter_limit_q > MaxLim) begin
      lim_eff = MaxLim;
    end else if (iter_limit_q == '0) begin
      lim_eff = LIMIT_W'(1);
    end else begin
      lim_eff = iter_limit_q;
    end
    at_limit = LIMIT_W'(steps_q) >= lim_eff;
    sum_ab   = {a_q[DATA_W-1], a_q} + {b_q[DATA_W-1], b_q};
    mid      = sum_ab[DATA_W:1];      // floor of half the sum
  end

  // shared multiplier: low or high 32 bits of the accumulator times x
  assign mul_p = mul_a * $signed({x_q[DATA_W-1], x_q});

  // horner combine: floor shift, saturate to 64 bits, add the next coefficient
  always_comb begin
    prod_full = ($signed({{(WideW-ProdW){pp_hi_q[ProdW-1]}}, pp_hi_q}) <<< DATA_W)
              + $signed({{(WideW-ProdW){pp_lo_q[ProdW-1]}}, pp_lo_q});
    prod_sh   = prod_full >>> FRAC_BITS;
    if (&prod_sh[WideW-1:ACC_W-1] || ~|prod_sh[WideW-1:ACC_W-1]) begin
      prod_sat = prod_sh[ACC_W-1:0];
    end else begin
      prod_sat = prod_sh[WideW-1] ? AccMin : AccMax;
    end
    add_sum = {prod_sat[ACC_W-1], prod_sat}
            + {{(ACC_W-DATA_W+1){coef_sel[DATA_W-1]}}, coef_sel};
    if (add_sum[ACC_W] != add_sum[ACC_W-1]) begin
      horner_next = add_sum[ACC_W] ? AccMin : AccMax;
    end else begin
      horner_next = add_sum[ACC_W-1:0];
    end
  end

  // value test at the midpoint and side selection
  always_comb begin
    fc_mag   = acc_q[ACC_W-1] ? ACC_W'(0) - acc_q : acc_q;
    fc_small = fc_mag < {{(ACC_W-TOL_W){1'b0}}, zero_thr_q};
    fc_neg   = acc_q[ACC_W-1];
    fc_pos   = !acc_q[ACC_W-1] && (acc_q != '0);
    go_left  = (fc_neg && fa_pos_q) || (fc_pos && fa_neg_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_CHECK;
      ST_CHECK:  state_d = (width_low || at_limit) ? ST_DONE : ST_MUL_LO;
      ST_MUL_LO: state_d = ST_MUL_HI;
      ST_MUL_HI: state_d = ST_ACC;
      ST_ACC:    state_d = (hstep_q == 2'd2) ? ST_TEST : ST_MUL_LO;
      ST_TEST: begin
        if (!eval_a_q && fc_small) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_CHECK;
        end
      end
      ST_DONE:   if (load_out) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    accept_in  = in_valid_i && (state_q == ST_IDLE);
    load_out   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
    mul_a      = (state_q == ST_MUL_HI) ? $signed({acc_q[ACC_W-1], acc_q[ACC_W-1:DATA_W]})
                                        : $signed({1'b0, acc_q[DATA_W-1:0]});
    unique case (hstep_q)
      2'd0:    coef_sel = coef_square_q;
      2'd1:    coef_sel = coef_linear_q;
      default: coef_sel = coef_const_q;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_cubic_q  <= CubicRst;
      coef_square_q <= SquareRst;
      coef_linear_q <= LinearRst;
      coef_const_q  <= '0;
      width_tol_q   <= TOL_W'(2);
      zero_thr_q    <= TOL_W'(1);
      iter_limit_q  <= LIMIT_W'(48);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_COEF_CUBIC:    coef_cubic_q  <= cfg_data_i;
        CFG_COEF_SQUARE:   coef_square_q <= cfg_data_i;
        CFG_COEF_LINEAR:   coef_linear_q <= cfg_data_i;
        CFG_COEF_CONSTANT: coef_const_q  <= cfg_data_i;
        CFG_WIDTH_TOL:     width_tol_q   <= cfg_data_i[TOL_W-1:0];
        CFG_ZERO_THRESH:   zero_thr_q    <= cfg_data_i[TOL_W-1:0];
        CFG_ITER_LIMIT:    iter_limit_q  <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (accept_in) begin
          a_q        <= start_low_i;
          b_q        <= start_high_i;
          c_q        <= '0;
          steps_q    <= '0;
          fa_known_q <= 1'b0;
        end
      end
      ST_CHECK: begin
        if (width_low) begin
          reason_q <= STOP_WIDTH;
        end else if (at_limit) begin
          reason_q <= STOP_LIMIT;
        end else begin
          hstep_q <= 2'd0;
          acc_q   <= ACC_W'(coef_cubic_q);
          // sign of f(a) is evaluated once; it follows a as the bracket moves
          if (!fa_known_q) begin
            x_q      <= a_q;
            eval_a_q <= 1'b1;
          end else begin
            x_q      <= mid;
            c_q      <= mid;
            steps_q  <= steps_q + CntW'(1);
            eval_a_q <= 1'b0;
          end
        end
      end
      ST_MUL_LO: pp_lo_q <= mul_p;
      ST_MUL_HI: pp_hi_q <= mul_p;
      ST_ACC: begin
        acc_q   <= horner_next;
        hstep_q <= hstep_q + 2'd1;
      end
      ST_TEST: begin
        if (eval_a_q) begin
          fa_known_q <= 1'b1;
          fa_neg_q   <= fc_neg;
          fa_pos_q   <= fc_pos;
        end else if (fc_small) begin
          reason_q <= STOP_ZERO;
        end else if (go_left) begin
          b_q <= c_q;
        end else begin
          a_q      <= c_q;
          fa_neg_q <= fc_neg;
          fa_pos_q <= fc_pos;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          root_q       <= c_q;
          steps_out_q  <= STEPS_W'(steps_q);
          reason_out_q <= reason_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign root_o        = root_q;
  assign steps_taken_o = steps_out_q;
  assign stop_reason_o = reason_out_q;

endmodule

[tb/bisection_cubic_root_top_tb.sv]
// self-checking testbench for bisection_cubic_root_top: random brackets, coefficient sets
// and handshake pressure, each result word checked against a fixed-point bisection predictor
// depends on bcr_pkg and the block's rtl only
`timescale 1ns / 100ps

module bisection_cubic_root_top_tb;
  import bcr_pkg::*;

  localparam int QUIET_LIMIT = 20000;  // cycles with no handshake before giving up
  localparam int END_WAIT    = 800;
  localparam int SETTLE      = 16;
  localparam int HOLD_CYCLES = 3000;   // long receiver hold-off to back the block up
  localparam int SMALL_SPAN  = 1 << 20;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct {
    logic signed [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] hi;
    logic signed [DATA_W-1:0] root;
    logic [STEPS_W-1:0]       steps;
    stop_reason_e             reason;
  } root_word_t;

  typedef struct {
    logic [DATA_W-1:0] c3;
    logic [DATA_W-1:0] c2;
    logic [DATA_W-1:0] c1;
    logic [DATA_W-1:0] c0;
    logic [DATA_W-1:0] tol;
    logic [DATA_W-1:0] thresh;
    logic [DATA_W-1:0] limit;
  } cfg_set_t;

  typedef enum int {RX_FLOW, RX_LIGHT, RX_HEAVY} rx_mode_e;

  // mirrors the register file and predicts one result word per bracket
  class root_scoreboard;
    logic signed [DATA_W-1:0] coef_x3, coef_x2, coef_x1, coef_x0;
    logic [TOL_W-1:0]         width_tol, zero_thresh;
    logic [LIMIT_W-1:0]       step_limit;
    root_word_t               pending[$];
    int                       errors;

    function new();
      coef_x3     = 2 <<< FRAC_BITS_DEF;
      coef_x2     = -(4 <<< FRAC_BITS_DEF);
      coef_x1     = 3 <<< FRAC_BITS_DEF;
      coef_x0     = 0;
      width_tol   = 2;
      zero_thresh = 1;
      step_limit  = 48;
      errors      = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        CFG_COEF_CUBIC:    coef_x3 = data;
        CFG_COEF_SQUARE:   coef_x2 = data;
        CFG_COEF_LINEAR:   coef_x1 = data;
        CFG_COEF_CONSTANT: coef_x0 = data;
        CFG_WIDTH_TOL:     width_tol = data[TOL_W-1:0];
        CFG_ZERO_THRESH:   zero_thresh = data[TOL_W-1:0];
        CFG_ITER_LIMIT:    step_limit = data[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    // floor(acc * x / 2^frac) from the exact product, clamped to 64 bits
    function logic signed [ACC_W-1:0] mul_floor_sat(logic signed [ACC_W-1:0] acc,
                                                    logic signed [DATA_W-1:0] x);
      logic signed [127:0] wide_acc, wide_x, prod;
      wide_acc = acc;
      wide_x   = x;
      prod     = (wide_acc * wide_x) >>> FRAC_BITS_DEF;
      if (&prod[127:ACC_W-1] || ~|prod[127:ACC_W-1]) return prod[ACC_W-1:0];
      return prod[127] ? ACC_MIN : ACC_MAX;
    endfunction

    function logic signed [ACC_W-1:0] horner_add(logic signed [ACC_W-1:0] acc,
                                                 logic signed [DATA_W-1:0] coef);
      logic signed [ACC_W:0] total;
      total = acc + coef;
      if (total[ACC_W] != total[ACC_W-1]) return total[ACC_W] ? ACC_MIN : ACC_MAX;
      return total[ACC_W-1:0];
    endfunction

    function logic signed [ACC_W-1:0] poly_at(logic signed [DATA_W-1:0] x);
      logic signed [ACC_W-1:0] acc;
      acc = coef_x3;
      acc = horner_add(mul_floor_sat(acc, x), coef_x2);
      acc = horner_add(mul_floor_sat(acc, x), coef_x1);
      acc = horner_add(mul_floor_sat(acc, x), coef_x0);
      return acc;
    endfunction

    function root_word_t solve_bracket(logic signed [DATA_W-1:0] lo,
                                       logic signed [DATA_W-1:0] hi);
      logic signed [ACC_W-1:0] a, b, mid, sum, fc, fa;
      logic [ACC_W-1:0]        span;
      logic [ACC_W:0]          fmag;
      int unsigned             steps, lim;
      bit                      done;
      root_word_t              r;
      a = lo;
      b = hi;
      mid = 0;
      steps = 0;
      done = 1'b0;
      r.lo = lo;
      r.hi = hi;
      r.reason = STOP_WIDTH;
      lim = (step_limit > MAX_STEPS_DEF) ? MAX_STEPS_DEF : step_limit;
      if (lim == 0) lim = 1;
      // width test, then step cap, then midpoint value test
      while (!done) begin
        span = (b > a) ? b - a : a - b;
        if (span < width_tol) begin
          r.reason = STOP_WIDTH;
          done = 1'b1;
        end else if (steps >= lim) begin
          r.reason = STOP_LIMIT;
          done = 1'b1;
        end else begin
          sum = a + b;
          mid = sum >>> 1;
          steps++;
          fc = poly_at(mid[DATA_W-1:0]);
          fmag = fc[ACC_W-1] ? -{fc[ACC_W-1], fc} : {1'b0, fc};
          if (fmag < zero_thresh) begin
            r.reason = STOP_ZERO;
            done = 1'b1;
          end else begin
            fa = poly_at(a[DATA_W-1:0]);
            // a zero value counts as neither sign, so the low end moves
            if ((fc < 0 && fa > 0) || (fc > 0 && fa < 0)) b = mid;
            else a = mid;
          end
        end
      end
      r.root  = mid[DATA_W-1:0];
      r.steps = STEPS_W'(steps);
      return r;
    endfunction

    function void note_bracket(logic signed [DATA_W-1:0] lo, logic signed [DATA_W-1:0] hi);
      pending.push_back(solve_bracket(lo, hi));
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 100) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_result(logic signed [DATA_W-1:0] root, logic [STEPS_W-1:0] steps,
                      logic [1:0] reason);
      root_word_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result word with no bracket pending, root %0d", root));
        return;
      end
      want = pending.pop_front();
      if (root !== want.root)
        report_mismatch($sformatf("[%0d,%0d] root %0d, want %0d",
                                  want.lo, want.hi, root, want.root));
      if (steps !== want.steps)
        report_mismatch($sformatf("[%0d,%0d] steps %0d, want %0d",
                                  want.lo, want.hi, steps, want.steps));
      if (reason !== want.reason)
        report_mismatch($sformatf("[%0d,%0d] stop reason %0d, want %0d",
                                  want.lo, want.hi, reason, want.reason));
    endtask
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [DATA_W-1:0]        cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [DATA_W-1:0] start_low;
  logic signed [DATA_W-1:0] start_high;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DATA_W-1:0] root;
  logic [STEPS_W-1:0]       steps_taken;
  logic [1:0]               stop_reason;
  bit                       hold_req;
  int                       quiet_cycles;
  root_scoreboard           board;

  bisection_cubic_root_top i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .start_low_i   (start_low),
    .start_high_i  (start_high),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .root_o        (root),
    .steps_taken_o (steps_taken),
    .stop_reason_o (stop_reason)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watchdog: any handshake or register write counts as progress
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side: check every accepted word, stall on a pattern of its own
  initial begin : receiver
    rx_mode_e mode;
    int       mode_left, hold_left;
    mode = RX_FLOW;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) board.check_result(root, steps_taken, stop_reason);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          RX_FLOW:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          default:  out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic send_bracket(input logic signed [DATA_W-1:0] lo,
                              input logic signed [DATA_W-1:0] hi);
    in_valid   <= 1'b1;
    start_low  <= lo;
    start_high <= hi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_bracket(lo, hi);
  endtask

  task automatic pick_bracket(output logic signed [DATA_W-1:0] lo,
                              output logic signed [DATA_W-1:0] hi);
    int                       kind, centre, half;
    logic signed [DATA_W-1:0] t;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      lo = $urandom;
      hi = $urandom;
    end else if (kind < 65) begin
      // region centred within SMALL_SPAN of zero
      centre = int'($urandom_range(0, 2 * SMALL_SPAN)) - SMALL_SPAN;
      half   = $urandom >> $urandom_range(9, 31);
      lo = centre - half;
      hi = centre + half;
    end else if (kind < 80) begin
      lo = $urandom;
      hi = lo + $urandom_range(0, 3);
    end else begin
      lo = int'($urandom) >>> $urandom_range(0, 31);
      hi = int'($urandom) >>> $urandom_range(0, 31);
    end
    if ($urandom_range(0, 3) == 0) begin
      t  = lo;
      lo = hi;
      hi = t;
    end
  endtask

  // bursts of random length, random gaps, some stretches with none
  task automatic feed_random(input int count);
    int                       left, burst, gap;
    logic signed [DATA_W-1:0] lo, hi;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && left > 0) begin
        pick_bracket(lo, hi);
        send_bracket(lo, hi);
        burst--;
        left--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0
          : $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // all seven registers, write enable held high across the sequence
  task automatic load_config(input cfg_set_t s);
    logic [CFG_IDX_W-1:0] order [7];
    logic [DATA_W-1:0]    value [7];
    order = '{CFG_COEF_CUBIC, CFG_COEF_SQUARE, CFG_COEF_LINEAR, CFG_COEF_CONSTANT,
              CFG_WIDTH_TOL, CFG_ZERO_THRESH, CFG_ITER_LIMIT};
    value = '{s.c3, s.c2, s.c1, s.c0, s.tol, s.thresh, s.limit};
    foreach (order[i]) begin
      cfg_we    <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= value[i];
      @(posedge clk);
      board.set_reg(order[i], value[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] small_coef();
    return int'($urandom_range(0, 1 << 20)) - (1 << 19);
  endfunction

  initial begin : stimulus
    cfg_set_t plan [6];
    int       count [6];
    board      = new();
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_COEF_CUBIC;
    cfg_data   = '0;
    in_valid   = 1'b0;
    start_low  = '0;
    start_high = '0;
    out_stall  = 1'b0;
    hold_req   = 1'b0;

    // random small coefficients, width down to zero, no value stop
    plan[0] = '{small_coef(), small_coef(), small_coef(), small_coef(), 1, 0, 64};
    // coefficient extremes, tolerance zero, huge threshold, limit zero acts as one
    plan[1] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                0, 32'h7FFF_FFFF, 0};
    // widest tolerance, limit above the cap
    plan[2] = '{32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                $urandom_range(0, 32'h7FFF_FFFF), 127};
    plan[3] = '{small_coef(), small_coef(), small_coef(), small_coef(),
                $urandom_range(1, 256), $urandom_range(0, 1 << 16), 8};
    plan[4] = '{$urandom, $urandom, $urandom, $urandom, $urandom_range(0, 4096),
                $urandom >> $urandom_range(1, 31), $urandom_range(1, 64)};
    // default cubic again, only the step cap can stop
    plan[5] = '{2 << FRAC_BITS_DEF, -(4 << FRAC_BITS_DEF), 3 << FRAC_BITS_DEF, 0, 0, 0, 64};
    count = '{260, 260, 260, 260, 260, 150};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words on the reset coefficients
    send_bracket(32'sd0, 32'sd0);                    // narrow start bracket
    send_bracket(32'h8000_0000, 32'h7FFF_FFFF);      // full range
    send_bracket(32'h7FFF_FFFF, 32'h8000_0000);      // full range, unordered
    send_bracket(-32'sd65536, 32'sd65536);           // midpoint hits the root at zero
    send_bracket(32'sd1, 32'sd2);                    // width just under tolerance
    send_bracket(32'sh0001_0000, 32'sh0003_0000);    // no root inside
    send_bracket(32'sd0, 32'sh0003_0000);            // value zero at the low end
    send_bracket(32'h8000_0000, 32'h8000_0000);
    send_bracket(32'h7FFF_FFFF, 32'h7FFF_FFFE);
    send_bracket(32'hFFFF_FFFF, 32'h0000_0001);      // width exactly tolerance
    send_bracket(32'h0000_0000, 32'hFFFF_FFFF);
    send_bracket(32'h5555_5555, 32'hAAAA_AAAA);
    send_bracket(32'hAAAA_AAAA, 32'h5555_5555);
    send_bracket(32'sh0010_0000, -32'sh0010_0000);

    // receiver backs off for a long stretch while words keep coming
    hold_req = 1'b1;
    feed_random(300);
    drain();

    foreach (plan[p]) begin
      repeat (SETTLE) @(posedge clk);
      load_config(plan[p]);
      feed_random(count[p]);
      drain();
    end

    repeat (END_WAIT) @(posedge clk);
    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
